@@ src/wwts_pkg.sv @@
// wwts_pkg: shared widths, opcodes, register map, unit control struct
// and Q1.16 geometric weights, Q2.16 sums, for the wake-word trigger smoother.
// No dependencies.
package wwts_pkg;

  localparam int WINDOWS_DEF = 8;

  localparam int SCORE_W    = 16;
  localparam int WEIGHT_W   = 17;
  localparam int SUM_W      = 18;
  localparam int PROD_W     = SCORE_W + WEIGHT_W;
  localparam int ACC_W      = SCORE_W + SUM_W;
  localparam int STEP_W     = 4;
  localparam int HITS_W     = 4;
  localparam int TICK_W     = 16;
  localparam int DIV_STEPS  = SCORE_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;

  localparam logic [1:0] OP_FRAME = 2'd0;
  localparam logic [1:0] OP_TICK  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_HITS      = 2'd1;
  localparam logic [1:0] REG_COOLDOWN  = 2'd2;

  localparam logic [SCORE_W-1:0] THRESHOLD_RESET = 16'd45875;
  localparam logic [HITS_W-1:0]  HITS_RESET      = 4'd3;
  localparam logic [TICK_W-1:0]  COOLDOWN_RESET  = 16'd2000;

  typedef struct packed {
    logic              acc_clr;
    logic              mac_en;
    logic              div_load;
    logic              div_step;
    logic [STEP_W-1:0] step;
  } unit_ctl_t;

  // round(65536 * 0.6^i)
  function automatic logic [WEIGHT_W-1:0] weight_q16(input logic [STEP_W-1:0] i);
    case (i)
      4'd0:    return 17'd65536;
      4'd1:    return 17'd39322;
      4'd2:    return 17'd23593;
      4'd3:    return 17'd14156;
      4'd4:    return 17'd8493;
      4'd5:    return 17'd5096;
      4'd6:    return 17'd3058;
      4'd7:    return 17'd1835;
      4'd8:    return 17'd1101;
      4'd9:    return 17'd660;
      4'd10:   return 17'd396;
      4'd11:   return 17'd238;
      4'd12:   return 17'd143;
      4'd13:   return 17'd86;
      4'd14:   return 17'd51;
      4'd15:   return 17'd31;
      default: return 17'd0;
    endcase
  endfunction

  // sum of weights 0..last
  function automatic logic [SUM_W-1:0] weight_total(input logic [STEP_W-1:0] last);
    case (last)
      4'd0:    return 18'd65536;
      4'd1:    return 18'd104858;
      4'd2:    return 18'd128451;
      4'd3:    return 18'd142607;
      4'd4:    return 18'd151100;
      4'd5:    return 18'd156196;
      4'd6:    return 18'd159254;
      4'd7:    return 18'd161089;
      4'd8:    return 18'd162190;
      4'd9:    return 18'd162850;
      4'd10:   return 18'd163246;
      4'd11:   return 18'd163484;
      4'd12:   return 18'd163627;
      4'd13:   return 18'd163713;
      4'd14:   return 18'd163764;
      4'd15:   return 18'd163795;
      default: return 18'd65536;
    endcase
  endfunction

endpackage

@@ src/wwts_unit.sv @@
// wwts_unit: shared arithmetic unit, one multiply-accumulate per cycle
// followed by a restoring divider that retires one quotient bit per cycle.
// Depends on wwts_pkg.
module wwts_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  wwts_pkg::unit_ctl_t               ctl,
  input  logic [wwts_pkg::SCORE_W-1:0]      score,
  input  logic [wwts_pkg::SUM_W-1:0]        total,
  output logic [wwts_pkg::SCORE_W-1:0]      quotient
);
  import wwts_pkg::*;

  logic [PROD_W-1:0]  prod;
  logic               prod_vld;
  logic [ACC_W-1:0]   acc;
  logic [ACC_W-1:0]   num;
  logic [SUM_W-1:0]   rem;
  logic [SCORE_W-1:0] low;
  logic [SUM_W:0]     shifted;
  logic [SUM_W:0]     divisor;
  logic               ge;

  // rounding: add half the weight total before dividing
  assign num     = acc + (prod_vld ? ACC_W'(prod) : '0) + ACC_W'(total >> 1);
  assign shifted = {rem, low[SCORE_W-1]};
  assign divisor = {1'b0, total};
  assign ge      = (shifted >= divisor);

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_vld <= 1'b0;
    end else begin
      prod_vld <= ctl.mac_en;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.mac_en) begin
      prod <= PROD_W'(score) * PROD_W'(weight_q16(ctl.step));
    end
    if (ctl.acc_clr) begin
      acc <= '0;
    end else if (prod_vld) begin
      acc <= acc + ACC_W'(prod);
    end
    // quotient fits in 16 bits, so the upper part starts below the divisor
    if (ctl.div_load) begin
      rem <= num[ACC_W-1:SCORE_W];
      low <= num[SCORE_W-1:0];
    end else if (ctl.div_step) begin
      rem <= ge ? SUM_W'(shifted - divisor) : shifted[SUM_W-1:0];
      low <= {low[SCORE_W-2:0], ge};
    end
  end

  assign quotient = low;

endmodule

@@ src/wwts_seq.sv @@
// wwts_seq: sequencer that walks the score ring newest first through the
// shared unit, then runs the divide steps and hands over the result.
// Other items go straight to the handover. Depends on wwts_pkg.
module wwts_seq #(
  parameter  int WINDOWS = wwts_pkg::WINDOWS_DEF,
  localparam int SLOT_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1,
  localparam int FILL_W  = $clog2(WINDOWS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                is_frame,
  input  logic [SLOT_W-1:0]   start_slot,
  input  logic [FILL_W-1:0]   fill_level,
  input  logic                out_free,
  output logic                busy,
  output logic                fin,
  output logic [SLOT_W-1:0]   rd_slot,
  output wwts_pkg::unit_ctl_t ctl
);
  import wwts_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MAC  = 5'b00010,
    S_SUM  = 5'b00100,
    S_DIV  = 5'b01000,
    S_FIN  = 5'b10000
  } seq_state_t;

  seq_state_t           state, state_next;
  logic [FILL_W-1:0]    step, step_next;
  logic [SLOT_W-1:0]    rd, rd_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  always_comb begin
    state_next   = state;
    step_next    = step;
    rd_next      = rd;
    div_cnt_next = div_cnt;
    ctl          = '0;
    fin          = 1'b0;
    case (state)
      S_IDLE: begin
        if (start) begin
          if (is_frame) begin
            state_next  = S_MAC;
            step_next   = '0;
            rd_next     = start_slot;
            ctl.acc_clr = 1'b1;
          end else begin
            state_next = S_FIN;
          end
        end
      end
      S_MAC: begin
        ctl.mac_en = 1'b1;
        ctl.step   = STEP_W'(step);
        if (step == fill_level - FILL_W'(1)) begin
          state_next = S_SUM;
        end else begin
          step_next = step + FILL_W'(1);
          rd_next   = (rd == '0) ? SLOT_W'(WINDOWS - 1) : rd - SLOT_W'(1);
        end
      end
      S_SUM: begin
        ctl.div_load = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_FIN;
        end else begin
          div_cnt_next = div_cnt + DIV_CNT_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          fin        = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      step    <= '0;
      rd      <= '0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      rd      <= rd_next;
      div_cnt <= div_cnt_next;
    end
  end

  assign busy    = (state != S_IDLE);
  assign rd_slot = rd;

endmodule

@@ src/wake_word_trigger_smoother.sv @@
// wake_word_trigger_smoother: top level with register port, score ring,
// trigger state and result register. Depends on wwts_pkg, wwts_seq, wwts_unit.
// Frame: one multiply-accumulate per filled ring entry, then 16 divide steps in
//   the shared unit, before the result is registered.
// Tick, clear, unused opcode: no ring walk, result registered from S_FIN.
// One item at a time: next item taken the cycle after its result is loaded.
// Reset (rst, synchronous) clears trigger state and restores register defaults.
module wake_word_trigger_smoother #(
  parameter  int WINDOWS = wwts_pkg::WINDOWS_DEF,
  localparam int SLOT_W  = (WINDOWS > 1) ? $clog2(WINDOWS) : 1,
  localparam int FILL_W  = $clog2(WINDOWS + 1)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [wwts_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [wwts_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [wwts_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                              pready,
  input  logic                              item_valid,
  output logic                              item_stall,
  input  logic [1:0]                        opcode,
  input  logic [wwts_pkg::SCORE_W-1:0]      class_score,
  output logic                              result_valid,
  input  logic                              result_stall,
  output logic                              fired,
  output logic [wwts_pkg::SCORE_W-1:0]      avg_score,
  output logic [wwts_pkg::HITS_W-1:0]       hit_run,
  output logic                              cooling_down
);
  import wwts_pkg::*;

  logic [SCORE_W-1:0] score_threshold;
  logic [HITS_W-1:0]  hits_required;
  logic [TICK_W-1:0]  cooldown_ticks;

  logic [SCORE_W-1:0] score_ring [WINDOWS];
  logic [SLOT_W-1:0]  write_slot;
  logic [FILL_W-1:0]  fill_level;
  logic [HITS_W-1:0]  hit_counter, hit_counter_next;
  logic               cooldown_flag, cooldown_flag_next;
  logic [TICK_W-1:0]  cooldown_elapsed, cooldown_elapsed_next;
  logic               fire_next;
  logic               blocked;
  logic               op_frame;

  logic               cfg_wr;
  logic               accept;
  logic               out_free;
  logic               busy;
  logic               fin;
  logic [SLOT_W-1:0]  rd_slot;
  unit_ctl_t          ctl;
  logic [SCORE_W-1:0] quotient;
  logic [SUM_W-1:0]   total;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign accept   = item_valid && !item_stall;
  assign out_free = !result_valid || !result_stall;
  assign item_stall = busy;
  assign total    = weight_total(STEP_W'(fill_level - FILL_W'(1)));

  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold <= THRESHOLD_RESET;
      hits_required   <= HITS_RESET;
      cooldown_ticks  <= COOLDOWN_RESET;
    end else if (cfg_wr) begin
      case (paddr[CFG_ADDR_W-1:2])
        REG_THRESHOLD: score_threshold <= pwdata[SCORE_W-1:0];
        REG_HITS:      hits_required   <= pwdata[HITS_W-1:0];
        REG_COOLDOWN:  cooldown_ticks  <= pwdata[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[CFG_ADDR_W-1:2])
      REG_THRESHOLD: prdata = CFG_DATA_W'(score_threshold);
      REG_HITS:      prdata = CFG_DATA_W'(hits_required);
      REG_COOLDOWN:  prdata = CFG_DATA_W'(cooldown_ticks);
      default:       prdata = '0;
    endcase
  end

  wwts_seq #(
    .WINDOWS(WINDOWS)
  ) u_seq (
    .clk        (clk),
    .rst        (rst),
    .start      (accept),
    .is_frame   (opcode == OP_FRAME),
    .start_slot (write_slot),
    .fill_level (fill_level),
    .out_free   (out_free),
    .busy       (busy),
    .fin        (fin),
    .rd_slot    (rd_slot),
    .ctl        (ctl)
  );

  wwts_unit u_unit (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .score    (score_ring[rd_slot]),
    .total    (total),
    .quotient (quotient)
  );

  // hit test and trigger decision, applied when a frame result is loaded with the ring full
  always_comb begin
    hit_counter_next      = hit_counter;
    cooldown_flag_next    = cooldown_flag;
    cooldown_elapsed_next = cooldown_elapsed;
    fire_next             = 1'b0;
    blocked               = 1'b0;
    if (op_frame && (fill_level == FILL_W'(WINDOWS))) begin
      if (cooldown_flag) begin
        if (cooldown_elapsed < cooldown_ticks) begin
          blocked = 1'b1;
        end else begin
          cooldown_flag_next = 1'b0;
          hit_counter_next   = '0;
        end
      end
      if (!blocked) begin
        if (quotient >= score_threshold) begin
          if (hit_counter_next != '1) begin
            hit_counter_next = hit_counter_next + HITS_W'(1);
          end
        end else begin
          hit_counter_next = '0;
        end
        if (hit_counter_next >= hits_required) begin
          fire_next             = 1'b1;
          cooldown_flag_next    = 1'b1;
          cooldown_elapsed_next = '0;
          hit_counter_next      = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot       <= '0;
      fill_level       <= '0;
      hit_counter      <= '0;
      cooldown_flag    <= 1'b0;
      cooldown_elapsed <= '0;
      result_valid     <= 1'b0;
    end else begin
      if (accept) begin
        case (opcode)
          OP_FRAME: begin
            write_slot <= (write_slot == SLOT_W'(WINDOWS - 1)) ? '0 : write_slot + SLOT_W'(1);
            if (fill_level != FILL_W'(WINDOWS)) begin
              fill_level <= fill_level + FILL_W'(1);
            end
          end
          OP_TICK: begin
            if (cooldown_flag && (cooldown_elapsed != '1)) begin
              cooldown_elapsed <= cooldown_elapsed + TICK_W'(1);
            end
          end
          OP_CLEAR: begin
            write_slot       <= '0;
            fill_level       <= '0;
            hit_counter      <= '0;
            cooldown_flag    <= 1'b0;
            cooldown_elapsed <= '0;
          end
          default: ;
        endcase
      end
      if (fin) begin
        hit_counter      <= hit_counter_next;
        cooldown_flag    <= cooldown_flag_next;
        cooldown_elapsed <= cooldown_elapsed_next;
      end
      if (fin) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // ring entries are only read once written since the last clear
  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_FRAME)) begin
      score_ring[write_slot] <= class_score;
    end
    if (accept) begin
      op_frame <= (opcode == OP_FRAME);
    end
    if (fin) begin
      fired        <= fire_next;
      avg_score    <= op_frame ? quotient : '0;
      hit_run      <= hit_counter_next;
      cooling_down <= cooldown_flag_next;
    end
  end

  a_busy_after_transfer: assert property (@(posedge clk) disable iff (rst)
    accept |=> item_stall)
    else $error("input not held off while an item is in work");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_level <= FILL_W'(WINDOWS))
    else $error("fill level beyond ring depth");

  a_fire_state: assert property (@(posedge clk) disable iff (rst)
    (result_valid && fired) |-> (cooling_down && (hit_run == '0)))
    else $error("trigger without cooldown or with live hit run");

endmodule
